// ===== src/cmis_pkg.sv =====
package cmis_pkg;

  // configuration register indexes
  localparam logic CFG_ENDPOINT_COUNT = 1'b0;
  localparam logic CFG_MAX_ALLOWED    = 1'b1;

  localparam int CFG_DW = 9;

  localparam logic [8:0] ENDPOINT_COUNT_RST = 9'd256;
  localparam logic [7:0] MAX_ALLOWED_RST    = 8'd128;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_wr;    // clearing pass write, advance counter
    logic load_wr;   // store one chord
    logic run_init;  // start of a run
    logic scan_rd;   // read chord table at sweep position
    logic i_inc;     // next sweep position
    logic left_rd;   // latch left end, read best at left + 1
    logic init_wr;   // record inner best, raise best at left end
    logic pop;       // pop pending position
    logic u_ld;      // latch popped position, read its best
    logic ln_rd;     // read entries one position left
    logic ln_eval;   // propagate to left neighbor, evaluate its chord
    logic cl_eval;   // update best at chord left end
    logic fin_rd;    // read best at position zero
    logic result;    // register the result word
  } cmis_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic lor_valid;
    logic stack_empty;
    logic u_zero;
    logic abort;
  } cmis_sts_t;

endpackage

// ===== src/cmis_ctrl.sv =====
module cmis_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                last_i,
  input  cmis_pkg::cmis_sts_t sts_i,
  output cmis_pkg::cmis_cmd_t cmd_o,
  output logic                busy_o
);
  import cmis_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SCAN_W = 4'd3;
  localparam logic [3:0] S_INIT_W = 4'd4;
  localparam logic [3:0] S_POP    = 4'd5;
  localparam logic [3:0] S_POP_W  = 4'd6;
  localparam logic [3:0] S_RD_U   = 4'd7;
  localparam logic [3:0] S_RD_LN  = 4'd8;
  localparam logic [3:0] S_RD_CL  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_FIN_W  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_wr = 1'b1;
          if (last_i) begin
            cmd_o.run_init = 1'b1;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_FIN;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = S_SCAN_W;
        end
      end
      S_SCAN_W: begin
        if (sts_i.lor_valid) begin
          cmd_o.left_rd = 1'b1;
          state_d = S_INIT_W;
        end else begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_INIT_W: begin
        cmd_o.init_wr = 1'b1;
        state_d = S_POP;
      end
      S_POP: begin
        if (sts_i.stack_empty) begin
          cmd_o.i_inc = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_POP_W;
        end
      end
      S_POP_W: begin
        cmd_o.u_ld = 1'b1;
        state_d = sts_i.u_zero ? S_POP : S_RD_U;
      end
      S_RD_U: begin
        cmd_o.ln_rd = 1'b1;
        state_d = S_RD_LN;
      end
      S_RD_LN: begin
        cmd_o.ln_eval = 1'b1;
        if (sts_i.abort) state_d = S_FIN;
        else if (sts_i.lor_valid) state_d = S_RD_CL;
        else state_d = S_POP;
      end
      S_RD_CL: begin
        cmd_o.cl_eval = 1'b1;
        state_d = S_POP;
      end
      S_FIN: begin
        cmd_o.fin_rd = 1'b1;
        state_d = S_FIN_W;
      end
      S_FIN_W: begin
        cmd_o.result = 1'b1;
        state_d = S_CLEAR;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== src/cmis_dp.sv =====
module cmis_dp #(
  parameter int MAX_ENDPOINTS = 256,
  parameter int STACK_DEPTH   = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cmis_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic [7:0]                  left_end_i,
  input  logic [7:0]                  right_end_i,
  input  cmis_pkg::cmis_cmd_t         cmd_i,
  output cmis_pkg::cmis_sts_t         sts_o,
  output logic                        result_valid_o,
  output logic [7:0]                  mis_size_o,
  output logic                        exceeded_o,
  output logic                        stack_overflow_o
);
  import cmis_pkg::*;

  localparam int PW = $clog2(MAX_ENDPOINTS);
  localparam int RW = $clog2(MAX_ENDPOINTS + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(STACK_DEPTH + 1);

  // configuration
  logic [8:0] ep_count_q;
  logic [7:0] max_allowed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ep_count_q    <= ENDPOINT_COUNT_RST;
      max_allowed_q <= MAX_ALLOWED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENDPOINT_COUNT: ep_count_q    <= cfg_wdata_i[8:0];
        CFG_MAX_ALLOWED:    max_allowed_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // memories
  logic [PW:0]   lor_mem [MAX_ENDPOINTS];
  logic [7:0]    bf_mem  [MAX_ENDPOINTS];
  logic [7:0]    ib_mem  [MAX_ENDPOINTS];
  logic [PW-1:0] st_mem  [STACK_DEPTH];

  logic [PW:0]   lor_rd_q;
  logic [7:0]    bf_rd_q, ib_rd_q;
  logic [PW-1:0] st_rd_q;

  // run registers
  logic [RW-1:0] run_end_q, i_q;
  logic [PW-1:0] clr_q, left_q, u_q, cl_q;
  logic [7:0]    bu_q, cand_q;
  logic [TW-1:0] top_q;
  logic          ovf_q, exc_q;
  logic          res_valid_q, res_exc_q, res_ovf_q;
  logic [7:0]    res_size_q;

  logic [PW-1:0] ip, ln, lor_left;
  logic          lor_vld, chord_ok, stk_full;
  logic [8:0]    init_sum;
  logic [7:0]    init_val;
  logic [9:0]    cand;
  logic          ln_improve, cl_improve, abort;
  logic [12:0]   ec_ext;
  logic [RW-1:0] run_end_d;

  assign ip       = i_q[PW-1:0];
  assign ln       = u_q - PW'(1);
  assign lor_vld  = lor_rd_q[PW];
  assign lor_left = lor_rd_q[PW-1:0];
  assign chord_ok = (left_end_i < right_end_i) &&
                    ({5'd0, right_end_i} < 13'(MAX_ENDPOINTS));
  assign stk_full = (top_q == TW'(STACK_DEPTH));
  assign init_sum = {1'b0, bf_rd_q} + 9'd1;
  assign init_val = init_sum[8] ? 8'hFF : init_sum[7:0];
  assign cand     = {2'b0, ib_rd_q} + {2'b0, bu_q} + 10'd1;
  assign ln_improve = bu_q > bf_rd_q;
  assign cl_improve = cand_q > bf_rd_q;
  assign abort    = lor_vld && (cand > {2'b0, max_allowed_q});
  assign ec_ext   = {4'd0, ep_count_q};
  assign run_end_d = (ec_ext > 13'(MAX_ENDPOINTS)) ? RW'(MAX_ENDPOINTS) : RW'(ec_ext);

  // chord table port
  logic          lor_we;
  logic [PW-1:0] lor_wa, lor_ra;
  logic [PW:0]   lor_wd;

  always_comb begin
    lor_we = 1'b0;
    lor_wa = clr_q;
    lor_wd = '0;
    if (cmd_i.clr_wr) begin
      lor_we = 1'b1;
    end else if (cmd_i.load_wr && chord_ok) begin
      lor_we = 1'b1;
      lor_wa = PW'(right_end_i);
      lor_wd = {1'b1, PW'(left_end_i)};
    end
  end
  assign lor_ra = cmd_i.ln_rd ? ln : ip;

  // best table port
  logic          bf_we;
  logic [PW-1:0] bf_wa, bf_ra;
  logic [7:0]    bf_wd;

  always_comb begin
    bf_we = 1'b0;
    bf_wa = clr_q;
    bf_wd = '0;
    if (cmd_i.clr_wr) begin
      bf_we = 1'b1;
    end else if (cmd_i.init_wr) begin
      bf_we = 1'b1;
      bf_wa = left_q;
      bf_wd = init_val;
    end else if (cmd_i.ln_eval && ln_improve) begin
      bf_we = 1'b1;
      bf_wa = ln;
      bf_wd = bu_q;
    end else if (cmd_i.cl_eval && cl_improve) begin
      bf_we = 1'b1;
      bf_wa = cl_q;
      bf_wd = cand_q;
    end
  end

  always_comb begin
    bf_ra = '0;
    if (cmd_i.left_rd) bf_ra = lor_left + PW'(1);
    else if (cmd_i.u_ld) bf_ra = st_rd_q;
    else if (cmd_i.ln_rd) bf_ra = ln;
    else if (cmd_i.ln_eval) bf_ra = lor_left;
  end

  // pending stack
  logic          push;
  logic [PW-1:0] push_pos;

  always_comb begin
    push     = 1'b0;
    push_pos = left_q;
    if (cmd_i.init_wr) begin
      push = 1'b1;
    end else if (cmd_i.ln_eval && ln_improve) begin
      push     = 1'b1;
      push_pos = ln;
    end else if (cmd_i.cl_eval && cl_improve) begin
      push     = 1'b1;
      push_pos = cl_q;
    end
  end

  logic [TW-1:0] top_m1;
  assign top_m1 = top_q - TW'(1);

  always_ff @(posedge clk_i) begin
    if (lor_we) lor_mem[lor_wa] <= lor_wd;
    lor_rd_q <= lor_mem[lor_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bf_we) bf_mem[bf_wa] <= bf_wd;
    bf_rd_q <= bf_mem[bf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) ib_mem[clr_q] <= '0;
    else if (cmd_i.init_wr) ib_mem[ip] <= bf_rd_q;
    ib_rd_q <= ib_mem[ln];
  end

  always_ff @(posedge clk_i) begin
    if (push && !stk_full) st_mem[top_q[SW-1:0]] <= push_pos;
    st_rd_q <= st_mem[top_m1[SW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      i_q         <= '0;
      run_end_q   <= '0;
      top_q       <= '0;
      ovf_q       <= 1'b0;
      exc_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.result;
      if (cmd_i.clr_wr) clr_q <= sts_o.clr_done ? '0 : clr_q + PW'(1);
      if (cmd_i.run_init) begin
        i_q       <= '0;
        run_end_q <= run_end_d;
        top_q     <= '0;
        ovf_q     <= 1'b0;
        exc_q     <= 1'b0;
      end else begin
        if (cmd_i.i_inc) i_q <= i_q + RW'(1);
        if (cmd_i.pop) top_q <= top_m1;
        else if (push && !stk_full) top_q <= top_q + TW'(1);
        if (push && stk_full) ovf_q <= 1'b1;
        if (cmd_i.ln_eval && abort) exc_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.left_rd) left_q <= lor_left;
    if (cmd_i.u_ld) u_q <= st_rd_q;
    if (cmd_i.ln_rd) bu_q <= bf_rd_q;
    if (cmd_i.ln_eval) begin
      cl_q   <= lor_left;
      cand_q <= cand[7:0];
    end
    if (cmd_i.result) begin
      res_size_q <= (exc_q || ovf_q) ? 8'd0 : bf_rd_q;
      res_exc_q  <= exc_q;
      res_ovf_q  <= ovf_q;
    end
  end

  assign sts_o.clr_done    = (clr_q == PW'(MAX_ENDPOINTS - 1));
  assign sts_o.scan_done   = (i_q >= run_end_q);
  assign sts_o.lor_valid   = lor_vld;
  assign sts_o.stack_empty = (top_q == '0);
  assign sts_o.u_zero      = (st_rd_q == '0);
  assign sts_o.abort       = abort;

  assign result_valid_o   = res_valid_q;
  assign mis_size_o       = res_size_q;
  assign exceeded_o       = res_exc_q;
  assign stack_overflow_o = res_ovf_q;

endmodule

// ===== src/circle_graph_mis_size.sv =====
// sequence: chords load one word per cycle; after the last word the sweep reads each position,
//   evaluates each stored chord and its pending pops, then reads the best at position zero
//   and registers the result word
// throughput: one chord word per cycle while idle; one run at a time, the next start
//   waits for the sweep plus a clearing pass over all MAX_ENDPOINTS entries of the tables
// reset: async active low; a clearing pass of the tables then runs with busy high;
//   the receiver cannot stall, each result word is strobed for one cycle
module circle_graph_mis_size #(
  parameter int MAX_ENDPOINTS = 256,
  parameter int STACK_DEPTH   = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command side
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [7:0]                  left_end_i,
  input  logic [7:0]                  right_end_i,
  input  logic                        last_i,
  // configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [cmis_pkg::CFG_DW-1:0] cfg_wdata_i,
  // result word
  output logic                        result_valid_o,
  output logic [7:0]                  mis_size_o,
  output logic                        exceeded_o,
  output logic                        stack_overflow_o
);
  import cmis_pkg::*;

  cmis_cmd_t cmd;
  cmis_sts_t sts;

  // sequencer: load, sweep, pending-stack propagation, result, clearing pass
  cmis_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .last_i  (last_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // tables, stack and comparators, one write and one read port per table
  cmis_dp #(
    .MAX_ENDPOINTS (MAX_ENDPOINTS),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .left_end_i       (left_end_i),
    .right_end_i      (right_end_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .result_valid_o   (result_valid_o),
    .mis_size_o       (mis_size_o),
    .exceeded_o       (exceeded_o),
    .stack_overflow_o (stack_overflow_o)
  );

`ifndef ASSERT_OFF
  // a result word only appears while a run is finishing
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside of a run");

  // the clearing pass follows every result
  a_res_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> busy_o) else $error("no clearing pass after result");

  // a final chord always starts a run
  a_last_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o) else $error("run did not start");

  // a flagged run reports no size
  a_flag_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (exceeded_o || stack_overflow_o)) |-> (mis_size_o == 8'd0))
    else $error("size reported with a flag set");

  // result strobe lasts one cycle
  a_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held");
`endif

endmodule
